// ===== design/sffdf_pkg.sv =====
package sffdf_pkg;

   // Default capture buffer size in bytes
   localparam int BUFFER_BYTES_DEF = 256;

   // Framing bytes
   localparam logic [7:0] START_BYTE = 8'hAB;
   localparam logic [7:0] END_BYTE   = 8'hBC;
   localparam logic [7:0] ESC_BYTE   = 8'hCD;
   localparam logic [7:0] ESC_START  = 8'hAC;
   localparam logic [7:0] ESC_END    = 8'hBD;
   localparam logic [7:0] ESC_ESC    = 8'hCE;

   // Header byte positions
   localparam int POS_LEN_LO  = 0;
   localparam int POS_LEN_HI  = 1;
   localparam int POS_VERSION = 2;
   localparam int POS_SEQ_LO  = 3;
   localparam int POS_SEQ_HI  = 4;
   localparam int POS_TYPE    = 5;
   localparam int POS_OFFSET  = 6;
   localparam int POS_FLAGS   = 7;
   localparam int POS_RSSI    = 9;

   // Positions relative to the header offset
   localparam int MAC_LAST  = 18;
   localparam int MAC_BYTES = 6;
   localparam int SIG_POS0  = 20;
   localparam int SIG_POS1  = 21;
   localparam int SIG_POS2  = 22;
   localparam int ODID_OFS  = 24;
   localparam int ODID_TRIM = 17;

   // Beacon signature and header checks
   localparam logic [7:0] SIG_BYTE0    = 8'h16;
   localparam logic [7:0] SIG_BYTE1    = 8'hFA;
   localparam logic [7:0] SIG_BYTE2    = 8'hFF;
   localparam logic [7:0] VERSION_OK   = 8'h03;
   localparam logic [7:0] TYPE_ADV     = 8'h02;
   localparam logic [7:0] TYPE_ADV_EXT = 8'h06;
   localparam int         MIN_FRAME    = 6;
   localparam int         LEN_FLOOR    = 22;
   localparam int         LEN_MARGIN   = 10;
   localparam int         STORE_MARGIN = 4;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_END   = 2'd1,
      KIND_ABORT = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      CMD_DATA,
      CMD_ABORT,
      CMD_END
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
      logic [7:0] value;
   } cmd_type;

   typedef enum logic [1:0] {
      FE_IDLE,
      FE_BODY,
      FE_ESCAPE
   } fe_state_type;

endpackage

// ===== design/sffdf_req_if.sv =====
interface sffdf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== design/sffdf_rsp_if.sv =====
interface sffdf_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic [7:0]         data_byte;
   logic [7:0]         byte_index;
   logic               accepted;
   logic [47:0]        mac_addr;
   logic signed [8:0]  signal_strength;
   logic [7:0]         odid_start;
   logic signed [8:0]  odid_length;
   logic [15:0]        sequence_number;
   logic [7:0]         packet_type;
   logic [7:0]         frame_length;

   modport source (output valid, output kind, output data_byte, output byte_index,
                   output accepted, output mac_addr, output signal_strength,
                   output odid_start, output odid_length, output sequence_number,
                   output packet_type, output frame_length, input ready);
   modport sink   (input valid, input kind, input data_byte, input byte_index,
                   input accepted, input mac_addr, input signal_strength,
                   input odid_start, input odid_length, input sequence_number,
                   input packet_type, input frame_length, output ready);
endinterface

// ===== design/sffdf_front.sv =====
module sffdf_front #(
   parameter int BUFFER_BYTES = sffdf_pkg::BUFFER_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   sffdf_req_if.sink         req_ch,
   input  logic              q_full,
   output logic              q_push,
   output sffdf_pkg::cmd_type q_cmd
);
   import sffdf_pkg::*;

   localparam int IDX_W = $clog2(BUFFER_BYTES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUFFER_BYTES - STORE_MARGIN);

   fe_state_type     state_ff, state_in;
   logic [IDX_W-1:0] count_ff, count_in;
   logic             fire;
   logic             store;
   logic [7:0]       store_val;

   assign req_ch.ready = !q_full;
   assign fire         = req_ch.valid && req_ch.ready;

   // Classify the word and build the queue command
   always_comb begin
      store     = 1'b0;
      store_val = req_ch.rx_byte;
      q_push    = 1'b0;
      q_cmd     = '{op: CMD_DATA, value: req_ch.rx_byte};
      unique case (state_ff)
         FE_IDLE: begin
         end
         FE_BODY: begin
            if (req_ch.rx_byte == END_BYTE) begin
               q_push   = fire;
               q_cmd.op = CMD_END;
            end else if (req_ch.rx_byte != ESC_BYTE) begin
               store = 1'b1;
            end
         end
         FE_ESCAPE: begin
            priority if (req_ch.rx_byte == ESC_START) begin
               store     = 1'b1;
               store_val = START_BYTE;
            end else if (req_ch.rx_byte == ESC_END) begin
               store     = 1'b1;
               store_val = END_BYTE;
            end else if (req_ch.rx_byte == ESC_ESC) begin
               store     = 1'b1;
               store_val = ESC_BYTE;
            end else begin
               store = 1'b0;
            end
         end
      endcase
      if (store) begin
         q_push      = fire;
         q_cmd.value = store_val;
         q_cmd.op    = (count_ff == LAST_IDX) ? CMD_ABORT : CMD_DATA;
      end
   end

   // Advance framing state and stored byte count
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      if (fire) begin
         unique case (state_ff)
            FE_IDLE: begin
               if (req_ch.rx_byte == START_BYTE) begin
                  state_in = FE_BODY;
                  count_in = '0;
               end
            end
            FE_BODY, FE_ESCAPE: begin
               if (state_ff == FE_BODY && req_ch.rx_byte == ESC_BYTE) begin
                  state_in = FE_ESCAPE;
               end else if (q_push && q_cmd.op == CMD_DATA) begin
                  state_in = FE_BODY;
                  count_in = count_ff + IDX_W'(1);
               end else if (q_push) begin
                  state_in = FE_IDLE;
                  count_in = '0;
               end else begin
                  state_in = FE_BODY;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FE_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== design/sffdf_queue.sv =====
module sffdf_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  sffdf_pkg::cmd_type push_cmd,
   output logic               full,
   output logic               head_valid,
   output sffdf_pkg::cmd_type head_cmd,
   input  logic               pop
);
   import sffdf_pkg::*;

   localparam int DEPTH = 2;

   cmd_type    entry_ff [DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full       = (count_ff == 2'(DEPTH));
   assign head_valid = (count_ff != 2'd0);
   assign head_cmd   = entry_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed command
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== design/sffdf_back.sv =====
module sffdf_back #(
   parameter int BUFFER_BYTES = sffdf_pkg::BUFFER_BYTES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  sffdf_pkg::cmd_type q_cmd,
   output logic               q_pop,
   sffdf_rsp_if.source        rsp_ch
);
   import sffdf_pkg::*;

   localparam int IDX_W = $clog2(BUFFER_BYTES);
   localparam int CMP_W = (IDX_W > 9) ? IDX_W + 1 : 10;

   // Frame capture state
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [15:0]      dlen_ff, dlen_in;
   logic [7:0]       ver_ff, ver_in;
   logic [15:0]      seq_ff, seq_in;
   logic [7:0]       ftype_ff, ftype_in;
   logic [7:0]       off_ff, off_in;
   logic             crc_ff, crc_in;
   logic [7:0]       rssi_ff, rssi_in;
   logic [47:0]      addr_ff, addr_in;
   logic [2:0]       sig_ff, sig_in;

   // Output register
   logic              out_valid_ff, out_valid_in;
   kind_type          kind_ff, kind_in;
   logic [7:0]        data_ff, data_in;
   logic [7:0]        index_ff, index_in;
   logic              acc_ff, acc_in;
   logic [47:0]       mac_ff, mac_in;
   logic signed [8:0] rssi_neg_ff, rssi_neg_in;
   logic [7:0]        ostart_ff, ostart_in;
   logic signed [8:0] olen_ff, olen_in;
   logic [15:0]       oseq_ff, oseq_in;
   logic [7:0]        otype_ff, otype_in;
   logic [7:0]        flen_ff, flen_in;

   logic [CMP_W-1:0] j_ext;
   logic [CMP_W-1:0] off_ext;
   logic             ok;
   logic [15:0]      odid_diff;
   logic [7:0]       b;

   assign q_pop   = q_valid && (!out_valid_ff || rsp_ch.ready);
   assign j_ext   = CMP_W'(idx_ff);
   assign off_ext = CMP_W'(off_ff);
   assign b       = q_cmd.value;

   // Check the captured header at frame end
   assign ok = (idx_ff >= IDX_W'(MIN_FRAME))
      && (ver_ff == VERSION_OK)
      && (ftype_ff == TYPE_ADV || ftype_ff == TYPE_ADV_EXT)
      && (dlen_ff > 16'(LEN_FLOOR))
      && (dlen_ff < 16'(BUFFER_BYTES - LEN_MARGIN))
      && crc_ff
      && (sig_ff == 3'b111);

   assign odid_diff = dlen_ff - {8'd0, off_ff} - 16'(ODID_TRIM);

   // Capture header bytes and form the result word
   always_comb begin
      idx_in   = idx_ff;
      dlen_in  = dlen_ff;
      ver_in   = ver_ff;
      seq_in   = seq_ff;
      ftype_in = ftype_ff;
      off_in   = off_ff;
      crc_in   = crc_ff;
      rssi_in  = rssi_ff;
      addr_in  = addr_ff;
      sig_in   = sig_ff;

      out_valid_in = out_valid_ff && !rsp_ch.ready;
      kind_in      = kind_ff;
      data_in      = data_ff;
      index_in     = index_ff;
      acc_in       = acc_ff;
      mac_in       = mac_ff;
      rssi_neg_in  = rssi_neg_ff;
      ostart_in    = ostart_ff;
      olen_in      = olen_ff;
      oseq_in      = oseq_ff;
      otype_in     = otype_ff;
      flen_in      = flen_ff;

      if (q_pop) begin
         out_valid_in = 1'b1;
         data_in      = '0;
         index_in     = '0;
         acc_in       = 1'b0;
         mac_in       = '0;
         rssi_neg_in  = '0;
         ostart_in    = '0;
         olen_in      = '0;
         oseq_in      = '0;
         otype_in     = '0;
         flen_in      = '0;

         unique case (q_cmd.op)
            CMD_DATA, CMD_ABORT: begin
               if (idx_ff == IDX_W'(POS_LEN_LO))  dlen_in[7:0]  = b;
               if (idx_ff == IDX_W'(POS_LEN_HI))  dlen_in[15:8] = b;
               if (idx_ff == IDX_W'(POS_VERSION)) ver_in        = b;
               if (idx_ff == IDX_W'(POS_SEQ_LO))  seq_in[7:0]   = b;
               if (idx_ff == IDX_W'(POS_SEQ_HI))  seq_in[15:8]  = b;
               if (idx_ff == IDX_W'(POS_TYPE))    ftype_in      = b;
               if (idx_ff == IDX_W'(POS_OFFSET))  off_in        = b;
               if (idx_ff == IDX_W'(POS_FLAGS))   crc_in        = b[0];
               if (idx_ff == IDX_W'(POS_RSSI))    rssi_in       = b;

               // Address bytes run backward from the last address position
               for (int k = 0; k < MAC_BYTES; k++) begin
                  if (j_ext == off_ext + CMP_W'(MAC_LAST - k)) begin
                     addr_in[8*k +: 8] = b;
                  end
               end

               if (j_ext == off_ext + CMP_W'(SIG_POS0) && b == SIG_BYTE0) sig_in[0] = 1'b1;
               if (j_ext == off_ext + CMP_W'(SIG_POS1) && b == SIG_BYTE1) sig_in[1] = 1'b1;
               if (j_ext == off_ext + CMP_W'(SIG_POS2) && b == SIG_BYTE2) sig_in[2] = 1'b1;

               data_in  = b;
               index_in = 8'(idx_ff);
               idx_in   = idx_ff + IDX_W'(1);
               kind_in  = (q_cmd.op == CMD_ABORT) ? KIND_ABORT : KIND_DATA;
            end
            CMD_END: begin
               kind_in  = KIND_END;
               acc_in   = ok;
               oseq_in  = seq_ff;
               otype_in = ftype_ff;
               flen_in  = 8'(idx_ff);
               if (ok) begin
                  mac_in      = addr_ff;
                  rssi_neg_in = 9'sd0 - $signed({1'b0, rssi_ff});
                  ostart_in   = off_ff + 8'(ODID_OFS);
                  olen_in     = $signed(odid_diff[8:0]);
               end
            end
            default: begin
               out_valid_in = 1'b0;
            end
         endcase

         // Drop the frame state once the frame finishes or overflows
         if (q_cmd.op != CMD_DATA) begin
            idx_in   = '0;
            dlen_in  = '0;
            ver_in   = '0;
            seq_in   = '0;
            ftype_in = '0;
            off_in   = '0;
            crc_in   = 1'b0;
            rssi_in  = '0;
            addr_in  = '0;
            sig_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         dlen_ff      <= '0;
         ver_ff       <= '0;
         seq_ff       <= '0;
         ftype_ff     <= '0;
         off_ff       <= '0;
         crc_ff       <= 1'b0;
         rssi_ff      <= '0;
         addr_ff      <= '0;
         sig_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         dlen_ff      <= dlen_in;
         ver_ff       <= ver_in;
         seq_ff       <= seq_in;
         ftype_ff     <= ftype_in;
         off_ff       <= off_in;
         crc_ff       <= crc_in;
         rssi_ff      <= rssi_in;
         addr_ff      <= addr_in;
         sig_ff       <= sig_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Hold the result word until it is taken
   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      data_ff     <= data_in;
      index_ff    <= index_in;
      acc_ff      <= acc_in;
      mac_ff      <= mac_in;
      rssi_neg_ff <= rssi_neg_in;
      ostart_ff   <= ostart_in;
      olen_ff     <= olen_in;
      oseq_ff     <= oseq_in;
      otype_ff    <= otype_in;
      flen_ff     <= flen_in;
   end

   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.kind            = kind_ff;
   assign rsp_ch.data_byte       = data_ff;
   assign rsp_ch.byte_index      = index_ff;
   assign rsp_ch.accepted        = acc_ff;
   assign rsp_ch.mac_addr        = mac_ff;
   assign rsp_ch.signal_strength = rssi_neg_ff;
   assign rsp_ch.odid_start      = ostart_ff;
   assign rsp_ch.odid_length     = olen_ff;
   assign rsp_ch.sequence_number = oseq_ff;
   assign rsp_ch.packet_type     = otype_ff;
   assign rsp_ch.frame_length    = flen_ff;

endmodule

// ===== design/sniffer_frame_deframe_filter.sv =====
// Channel   Direction  Payload
// req_ch    in         rx_byte: one raw serial byte per word
// rsp_ch    out        kind, data_byte, byte_index, verdict and header fields
//
// Sustains one word per cycle while rsp_ch.ready is high; results are registered.
// Throughput is set by the front deframer and the back capture stage, one word each.
// Reset is synchronous; no clearing pass follows.
// A two-entry queue parts front and back; req_ch.ready drops only while it is full.
// The result register holds its word while rsp_ch.ready is low.
module sniffer_frame_deframe_filter #(
   parameter int BUFFER_BYTES = sffdf_pkg::BUFFER_BYTES_DEF
) (
   input logic          clock,
   input logic          reset,
   sffdf_req_if.sink    req_ch,
   sffdf_rsp_if.source  rsp_ch
);
   import sffdf_pkg::*;

   logic    q_push;
   logic    q_full;
   logic    q_valid;
   logic    q_pop;
   cmd_type push_cmd;
   cmd_type head_cmd;

   // Deframe and classify incoming words
   sffdf_front #(.BUFFER_BYTES(BUFFER_BYTES)) u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .q_full (q_full),
      .q_push (q_push),
      .q_cmd  (push_cmd)
   );

   // Decouple front and back
   sffdf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .head_valid (q_valid),
      .head_cmd   (head_cmd),
      .pop        (q_pop)
   );

   // Capture header and emit results
   sffdf_back #(.BUFFER_BYTES(BUFFER_BYTES)) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_cmd   (head_cmd),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

   // A pass verdict is only ever a frame end word
   a_accept_is_end: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.accepted |-> rsp_ch.kind == KIND_END)
      else $error("accepted flag on a non-verdict word");

   // Beacon fields stay zero unless the frame passed
   a_fields_need_pass: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.accepted |-> rsp_ch.mac_addr == '0
         && rsp_ch.signal_strength == '0 && rsp_ch.odid_start == '0)
      else $error("beacon fields set without a pass verdict");

   // A command pushed without a pop leaves the queue non-empty
   a_queue_keeps: assert property (@(posedge clock) disable iff (reset)
      q_push && !q_pop |=> q_valid)
      else $error("queue lost a pushed command");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import sffdf_pkg::*;

   localparam int BUF_BYTES   = BUFFER_BYTES_DEF;
   localparam int ITEM_TARGET = 1850;
   localparam int HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int MAX_FILL    = BUF_BYTES - STORE_MARGIN;

   // One word on the result channel
   typedef struct {
      kind_type          kind;
      logic [7:0]        data_byte;
      logic [7:0]        byte_index;
      logic              accepted;
      logic [47:0]       mac_addr;
      logic signed [8:0] signal_strength;
      logic [7:0]        odid_start;
      logic signed [8:0] odid_length;
      logic [15:0]       sequence_number;
      logic [7:0]        packet_type;
      logic [7:0]        frame_length;
   } deframe_word_type;

   // Unstuffing deframer predictor plus the queue of words it expects
   class deframe_scoreboard;
      deframe_word_type pending_q[$];
      int            mismatches;
      int            buffer_bytes;
      bit            in_frame;
      bit            esc_seen;
      int unsigned   fill_count;
      logic [15:0]   len_field;
      logic [7:0]    version_field;
      logic [15:0]   seq_field;
      logic [7:0]    type_field;
      logic [7:0]    offset_field;
      bit            crc_flag;
      logic [7:0]    rssi_field;
      logic [47:0]   adv_addr;
      logic [2:0]    sig_mask;

      function new(int bytes);
         buffer_bytes = bytes;
         mismatches   = 0;
         in_frame     = 1'b0;
         restart_capture();
      endfunction

      function void restart_capture();
         esc_seen      = 1'b0;
         fill_count    = 0;
         len_field     = '0;
         version_field = '0;
         seq_field     = '0;
         type_field    = '0;
         offset_field  = '0;
         crc_flag      = 1'b0;
         rssi_field    = '0;
         adv_addr      = '0;
         sig_mask      = '0;
      endfunction

      function deframe_word_type empty_word();
         deframe_word_type w;
         w.kind            = KIND_DATA;
         w.data_byte       = '0;
         w.byte_index      = '0;
         w.accepted        = 1'b0;
         w.mac_addr        = '0;
         w.signal_strength = '0;
         w.odid_start      = '0;
         w.odid_length     = '0;
         w.sequence_number = '0;
         w.packet_type     = '0;
         w.frame_length    = '0;
         return w;
      endfunction

      // Store one unescaped byte, capture header fields, watch for overflow
      function void capture_byte(logic [7:0] b);
         deframe_word_type w;
         int unsigned   j;
         int unsigned   off;
         int unsigned   pos;
         j   = fill_count;
         off = 32'(offset_field);
         case (j)
            POS_LEN_LO:  len_field[7:0]  = b;
            POS_LEN_HI:  len_field[15:8] = b;
            POS_VERSION: version_field   = b;
            POS_SEQ_LO:  seq_field[7:0]  = b;
            POS_SEQ_HI:  seq_field[15:8] = b;
            POS_TYPE:    type_field      = b;
            POS_OFFSET:  offset_field    = b;
            POS_FLAGS:   crc_flag        = b[0];
            POS_RSSI:    rssi_field      = b;
            default: ;
         endcase
         // address is stored last byte first
         if (j >= off + MAC_LAST - MAC_BYTES + 1 && j <= off + MAC_LAST) begin
            pos = off + MAC_LAST - j;
            adv_addr[8*pos +: 8] = b;
         end
         if (j == off + SIG_POS0 && b == SIG_BYTE0) sig_mask[0] = 1'b1;
         if (j == off + SIG_POS1 && b == SIG_BYTE1) sig_mask[1] = 1'b1;
         if (j == off + SIG_POS2 && b == SIG_BYTE2) sig_mask[2] = 1'b1;
         fill_count   = j + 1;
         w            = empty_word();
         w.data_byte  = b;
         w.byte_index = j[7:0];
         if (fill_count > buffer_bytes - STORE_MARGIN) begin
            w.kind   = KIND_ABORT;
            in_frame = 1'b0;
            restart_capture();
         end else begin
            w.kind = KIND_DATA;
         end
         pending_q.push_back(w);
      endfunction

      // End of frame: judge the header and beacon signature
      function void finish_frame();
         deframe_word_type w;
         bit            good;
         int            len_calc;
         int            rssi_neg;
         good = fill_count >= MIN_FRAME && version_field == VERSION_OK
            && (type_field == TYPE_ADV || type_field == TYPE_ADV_EXT)
            && len_field > LEN_FLOOR && len_field < buffer_bytes - LEN_MARGIN
            && crc_flag && sig_mask == 3'b111;
         w          = empty_word();
         w.kind     = KIND_END;
         w.accepted = good;
         if (good) begin
            len_calc          = int'(len_field) - int'(offset_field) - ODID_TRIM;
            rssi_neg          = 0 - int'(rssi_field);
            w.mac_addr        = adv_addr;
            w.signal_strength = rssi_neg[8:0];
            w.odid_start      = 8'(offset_field + ODID_OFS);
            w.odid_length     = len_calc[8:0];
         end
         w.sequence_number = seq_field;
         w.packet_type     = type_field;
         w.frame_length    = fill_count[7:0];
         in_frame = 1'b0;
         restart_capture();
         pending_q.push_back(w);
      endfunction

      // Advance the predictor by one accepted serial byte
      function void note_byte(logic [7:0] c);
         if (!in_frame) begin
            if (c == START_BYTE) begin
               restart_capture();
               in_frame = 1'b1;
            end
         end else if (esc_seen) begin
            esc_seen = 1'b0;
            case (c)
               ESC_START: capture_byte(START_BYTE);
               ESC_END:   capture_byte(END_BYTE);
               ESC_ESC:   capture_byte(ESC_BYTE);
               default: ;  // drop unknown escape code
            endcase
         end else if (c == ESC_BYTE) begin
            esc_seen = 1'b1;
         end else if (c == END_BYTE) begin
            finish_frame();
         end else begin
            capture_byte(c);
         end
      endfunction

      task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
         $display("[%0t] mismatch %s: got %h want %h", $time, what, got, want);
         mismatches++;
      endtask

      task check_field(string what, logic [63:0] got, logic [63:0] want);
         if (got !== want) report_mismatch(what, got, want);
      endtask

      // Compare one result word against the oldest expected word
      task check_result(deframe_word_type got);
         deframe_word_type want;
         if (pending_q.size() == 0) begin
            report_mismatch("word with nothing pending, kind", 64'(got.kind), 64'd0);
         end else begin
            want = pending_q.pop_front();
            check_field("kind", 64'(got.kind), 64'(want.kind));
            check_field("data_byte", 64'(got.data_byte), 64'(want.data_byte));
            check_field("byte_index", 64'(got.byte_index), 64'(want.byte_index));
            check_field("accepted", 64'(got.accepted), 64'(want.accepted));
            check_field("mac_addr", 64'(got.mac_addr), 64'(want.mac_addr));
            check_field("signal_strength", 64'(got.signal_strength),
                        64'(want.signal_strength));
            check_field("odid_start", 64'(got.odid_start), 64'(want.odid_start));
            check_field("odid_length", 64'(got.odid_length), 64'(want.odid_length));
            check_field("sequence_number", 64'(got.sequence_number),
                        64'(want.sequence_number));
            check_field("packet_type", 64'(got.packet_type), 64'(want.packet_type));
            check_field("frame_length", 64'(got.frame_length), 64'(want.frame_length));
         end
      endtask
   endclass

   logic              clock;
   logic              reset;
   sffdf_req_if       req_ch();
   sffdf_rsp_if       rsp_ch();
   deframe_scoreboard sb;
   deframe_word_type  seen_word;
   int                cycle_count;
   int                frame_words;
   int                stall_left;
   bit                burst;
   bit                steady;
   bit                hold_rsp;

   sniffer_frame_deframe_filter #(.BUFFER_BYTES(BUF_BYTES)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Mostly short gaps, a few long ones, none in steady or burst stretches
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (burst || steady || r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Offer one word and hold it until the block takes it
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= b;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      sb.note_byte(b);
   endtask

   // Drop valid, then hold until every expected word is back
   task automatic wait_drain();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (sb.pending_q.size() != 0) @(posedge clock);
   endtask

   // Stuff and send one frame, with a few unknown escape codes mixed in
   task automatic send_frame(ref logic [7:0] body[$]);
      logic [7:0] odd;
      send_byte(START_BYTE);
      foreach (body[i]) begin
         if ($urandom_range(0, 99) < 3) begin
            do odd = 8'($urandom_range(0, 255));
            while (odd == ESC_START || odd == ESC_END || odd == ESC_ESC);
            send_byte(ESC_BYTE);
            send_byte(odd);
         end
         case (body[i])
            START_BYTE: begin
               if ($urandom_range(0, 1)) begin
                  send_byte(START_BYTE);
               end else begin
                  send_byte(ESC_BYTE);
                  send_byte(ESC_START);
               end
            end
            END_BYTE: begin
               send_byte(ESC_BYTE);
               send_byte(ESC_END);
            end
            ESC_BYTE: begin
               send_byte(ESC_BYTE);
               send_byte(ESC_ESC);
            end
            default: send_byte(body[i]);
         endcase
      end
      send_byte(END_BYTE);
      frame_words += body.size() + 2;
   endtask

   // Build a beacon frame that mostly passes, with occasional bad fields
   task automatic build_beacon(ref logic [7:0] body[$], input int force_off);
      int off;
      int flen;
      int dlen;
      int seqn;
      int r;
      r = $urandom_range(0, 99);
      if (force_off >= 0) off = force_off;
      else if (r < 70) off = $urandom_range(0, 12);
      else if (r < 98) off = $urandom_range(13, 60);
      else off = $urandom_range(180, MAX_FILL - SIG_POS2 - 1);
      flen = off + SIG_POS2 + 1 + $urandom_range(0, 12);
      if (flen > MAX_FILL) flen = MAX_FILL;
      body.delete();
      repeat (flen) body.push_back(8'($urandom_range(0, 255)));
      case ($urandom_range(0, 9))
         0:       dlen = LEN_FLOOR + 1;
         1:       dlen = BUF_BYTES - LEN_MARGIN - 1;
         2:       dlen = LEN_FLOOR;
         3:       dlen = BUF_BYTES - LEN_MARGIN;
         4:       dlen = $urandom_range(0, 65535);
         default: dlen = $urandom_range(LEN_FLOOR + 1, BUF_BYTES - LEN_MARGIN - 1);
      endcase
      seqn = $urandom_range(0, 65535);
      body[POS_LEN_LO] = dlen[7:0];
      body[POS_LEN_HI] = dlen[15:8];
      if ($urandom_range(0, 9) != 0) body[POS_VERSION] = VERSION_OK;
      body[POS_SEQ_LO] = seqn[7:0];
      body[POS_SEQ_HI] = seqn[15:8];
      r = $urandom_range(0, 99);
      if (r < 45) body[POS_TYPE] = TYPE_ADV;
      else if (r < 90) body[POS_TYPE] = TYPE_ADV_EXT;
      body[POS_OFFSET] = off[7:0];
      if ($urandom_range(0, 99) < 85) body[POS_FLAGS][0] = 1'b1;
      r = $urandom_range(0, 9);
      if (r == 0) body[POS_RSSI] = 8'h00;
      else if (r == 1) body[POS_RSSI] = 8'hFF;
      if ($urandom_range(0, 99) < 93) body[off + SIG_POS0] = SIG_BYTE0;
      if ($urandom_range(0, 99) < 93) body[off + SIG_POS1] = SIG_BYTE1;
      if ($urandom_range(0, 99) < 93) body[off + SIG_POS2] = SIG_BYTE2;
   endtask

   // Idle bytes between frames, never a start byte
   task automatic send_noise();
      logic [7:0] b;
      repeat ($urandom_range(0, 3)) begin
         do b = 8'($urandom_range(0, 255)); while (b == START_BYTE);
         send_byte(b);
      end
   endtask

   task automatic run_directed();
      logic [7:0] seq_list[$];
      // idle junk, empty frame, then every escape case and a raw start byte
      seq_list = {8'h00, 8'hFF, END_BYTE, ESC_BYTE, START_BYTE, END_BYTE,
                  START_BYTE, 8'h00, 8'hFF, ESC_BYTE, ESC_START, ESC_BYTE, ESC_END,
                  ESC_BYTE, ESC_ESC, ESC_BYTE, 8'h55, ESC_BYTE, END_BYTE,
                  START_BYTE, END_BYTE};
      foreach (seq_list[i]) send_byte(seq_list[i]);
   endtask

   task automatic run_random();
      logic [7:0] body[$];
      int         n;
      int         r;
      n = 0;
      while (frame_words < ITEM_TARGET) begin
         steady = ($urandom_range(0, 99) < 15);
         // long result stall while the sender keeps pushing
         burst = (n == 2);
         if (n == 2) hold_rsp = 1'b1;
         // sender pause until all results are back
         if (n == 5) wait_drain();
         r = $urandom_range(0, 99);
         if (n == 12) begin
            build_beacon(body, MAX_FILL - SIG_POS2 - 1);
            send_frame(body);
         end else if (n == 25 || n == 40) begin
            body.delete();
            repeat ($urandom_range(MAX_FILL + 1, MAX_FILL + 10))
               body.push_back(8'($urandom_range(0, 255)));
            send_frame(body);
         end else if (n == 2 || r < 75) begin
            build_beacon(body, -1);
            send_frame(body);
         end else if (r < 90) begin
            body.delete();
            repeat ($urandom_range(0, 99) < 30 ? $urandom_range(0, 8) : $urandom_range(9, 40))
               body.push_back(8'($urandom_range(0, 255)));
            send_frame(body);
         end else begin
            // raw unstuffed bytes: stray ends and escapes cut the frame anywhere
            send_byte(START_BYTE);
            repeat ($urandom_range(0, 30)) begin
               send_byte(8'($urandom_range(0, 255)));
               frame_words++;
            end
            send_byte(END_BYTE);
            frame_words += 2;
         end
         burst = 1'b0;
         send_noise();
         n++;
      end
   endtask

   // Result side: random stalls plus one long hold-off
   initial begin
      stall_left   = 0;
      rsp_ch.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end
         if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   // Sample result words on the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         seen_word.kind            = kind_type'(rsp_ch.kind);
         seen_word.data_byte       = rsp_ch.data_byte;
         seen_word.byte_index      = rsp_ch.byte_index;
         seen_word.accepted        = rsp_ch.accepted;
         seen_word.mac_addr        = rsp_ch.mac_addr;
         seen_word.signal_strength = rsp_ch.signal_strength;
         seen_word.odid_start      = rsp_ch.odid_start;
         seen_word.odid_length     = rsp_ch.odid_length;
         seen_word.sequence_number = rsp_ch.sequence_number;
         seen_word.packet_type     = rsp_ch.packet_type;
         seen_word.frame_length    = rsp_ch.frame_length;
         sb.check_result(seen_word);
      end
   end

   // Watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("sniffer_frame_deframe_filter regression: fail");
      $finish;
   end

   initial begin
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.rx_byte = 8'h00;
      burst          = 1'b0;
      steady         = 1'b0;
      hold_rsp       = 1'b0;
      frame_words    = 0;
      sb             = new(BUF_BYTES);
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      run_directed();
      run_random();
      // let the pipeline empty, then keep watching for stray words
      wait_drain();
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("sniffer_frame_deframe_filter regression: pass");
      end else begin
         $display("sniffer_frame_deframe_filter regression: fail");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/sffdf_pkg.sv
design/sffdf_req_if.sv
design/sffdf_rsp_if.sv
design/sffdf_front.sv
design/sffdf_queue.sv
design/sffdf_back.sv
design/sniffer_frame_deframe_filter.sv
tb/tb_top.sv
